### hdl/ufc_pkg.sv
package ufc_pkg;

    localparam int NODES  = 1024;
    localparam int ADDR_W = $clog2(NODES);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(NODES);
    localparam logic [0:0]       REG_NODE_COUNT = 1'b0;

    typedef enum logic [0:0] {
        CMD_UNION = 1'b0,
        CMD_FIND  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] node_a;
        logic [ADDR_W-1:0] node_b;
    } t_in;

    typedef struct packed {
        logic              merged;
        logic [ADDR_W-1:0] root_of_a;
        logic              a_is_root;
        logic [CNT_W-1:0]  component_count;
        logic              range_error;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic err;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_RESULT
    } t_state;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(NODES)) begin
            r = CNT_W'(NODES);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/union_find_components.sv
// disjoint-set table, union by size with path compression
// input queue: drive i_item and raise i_push; the item is taken when o_full is low.
//   command union links the sets of node_a and node_b, find returns node_a's root
// result queue: o_result holds the oldest result while o_empty is low; pop takes it
// one result per item, in order; a stalled result sits in the output register, one more
//   item finishes in the back end and waits, two more wait in the front queue, then
//   o_full rises
// a find walks node_a's parent chain to its root, then walks it again writing that root
//   into each entry; a union does this for node_a, then node_b, and if the sets differ
//   reads both set sizes and links the smaller set's root under the other; the back end
//   handles one item at a time, set by the single read port of the parent memory
// out-of-range nodes give range_error with no table change
// config: node_count at paddr 0; writing it restarts the table
// after reset and after each node_count write the table is swept, one entry a cycle,
//   over every entry, with o_full high; the count register is still writable
module union_find_components
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in         i_item,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_node_count;
    logic             cfg_wr;
    logic             job_valid;
    logic             job_pop;
    t_job             job;
    t_back_status     status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, r_node_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (cfg_wr) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    ufc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_status    (status),
        .i_item      (i_item),
        .i_eff_count (eff_count(r_node_count)),
        .o_full      (o_full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    ufc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (cfg_wr),
        .i_init_count (eff_count(pwdata[CNT_W-1:0])),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .o_status     (status),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_result     (o_result)
    );

endmodule

### hdl/ufc_ram.sv
module ufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ufc_front.sv
module ufc_front
    import ufc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_back_status     i_status,
    input  t_in              i_item,
    input  logic [CNT_W-1:0] i_eff_count,
    output logic             o_full,
    output logic             o_job_valid,
    output t_job             o_job,
    input  logic             i_job_pop
);

    t_job       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       acc;
    t_job       job_in;

    assign o_full      = (r_cnt == 2'd2) || i_status.clearing;
    assign acc         = i_push && !o_full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // node_b only matters for union
    always_comb begin
        job_in.item = i_item;
        job_in.err  = ({1'b0, i_item.node_a} >= i_eff_count) ||
                      (i_item.command == CMD_UNION && {1'b0, i_item.node_b} >= i_eff_count);
    end

    always_comb begin
        n_wp  = r_wp ^ acc;
        n_rp  = r_rp ^ (i_job_pop && o_job_valid);
        n_cnt = r_cnt + 2'(acc) - 2'(i_job_pop && o_job_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

### hdl/ufc_back.sv
module ufc_back
    import ufc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_init,
    input  logic [CNT_W-1:0] i_init_count,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_pop,
    output t_back_status     o_status,
    output logic             o_empty,
    input  logic             i_pop,
    output t_out             o_result
);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_a, n_a, r_b, n_b;
    logic              r_err, n_err;
    logic              r_phase, n_phase;
    logic [ADDR_W-1:0] r_cur, n_cur, r_idx, n_idx;
    logic [ADDR_W-1:0] r_root, n_root, r_ra, n_ra, r_rb, n_rb;
    logic [CNT_W-1:0]  r_sza, n_sza;
    logic              r_merged, n_merged;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_comp, n_comp;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              par_we;
    logic [ADDR_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic              sz_we;
    logic [ADDR_W-1:0] sz_waddr, sz_raddr;
    logic [CNT_W-1:0]  sz_wdata, sz_rdata;
    logic              slot_free;
    logic              a_small;

    ufc_ram #(.WIDTH(ADDR_W), .DEPTH(NODES)) u_parent (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rdata)
    );

    ufc_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_size (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(sz_waddr), .i_wdata(sz_wdata),
        .i_raddr(sz_raddr), .o_rdata(sz_rdata)
    );

    assign slot_free         = !r_out_valid || i_pop;
    assign a_small           = (r_sza < sz_rdata);
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_empty           = !r_out_valid;
    assign o_result          = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_job_valid) n_state = i_job.err ? ST_RESULT : ST_FIND;
            end
            ST_FIND: begin
                if (par_rdata == r_cur) n_state = ST_COMP;
            end
            ST_COMP: begin
                if (r_idx == r_root) begin
                    if (!r_phase) begin
                        n_state = (r_cmd == CMD_FIND) ? ST_RESULT : ST_FIND;
                    end else begin
                        n_state = (r_ra == r_root) ? ST_RESULT : ST_SIZE_A;
                    end
                end
            end
            ST_SIZE_A: n_state = ST_SIZE_B;
            ST_SIZE_B: n_state = ST_RESULT;
            ST_RESULT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
        if (i_init) n_state = ST_CLEAR;
    end

    always_comb begin
        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_err = r_err; n_phase = r_phase;
        n_cur = r_cur; n_idx = r_idx; n_root = r_root; n_ra = r_ra; n_rb = r_rb;
        n_sza = r_sza; n_merged = r_merged; n_clr = r_clr; n_comp = r_comp;
        n_out_valid = r_out_valid && !i_pop;
        n_out = r_out;
        par_we = 1'b0; par_waddr = r_idx; par_wdata = r_root; par_raddr = r_cur;
        sz_we = 1'b0; sz_waddr = r_clr; sz_wdata = CNT_W'(1); sz_raddr = r_ra;
        o_job_pop = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                par_we    = 1'b1;
                par_waddr = r_clr;
                par_wdata = r_clr;
                sz_we     = 1'b1;
                n_clr     = r_clr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cmd     = i_job.item.command;
                    n_a       = i_job.item.node_a;
                    n_b       = i_job.item.node_b;
                    n_err     = i_job.err;
                    n_merged  = 1'b0;
                    n_phase   = 1'b0;
                    n_cur     = i_job.item.node_a;
                    par_raddr = i_job.item.node_a;
                end
            end
            ST_FIND: begin
                if (par_rdata == r_cur) begin
                    // root found, go back over the path from the start node
                    n_root    = r_cur;
                    n_idx     = r_phase ? r_b : r_a;
                    par_raddr = r_phase ? r_b : r_a;
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            ST_COMP: begin
                if (r_idx != r_root) begin
                    par_we    = 1'b1;
                    n_idx     = par_rdata;
                    par_raddr = par_rdata;
                end else if (!r_phase) begin
                    n_ra      = r_root;
                    n_phase   = 1'b1;
                    n_cur     = r_b;
                    par_raddr = r_b;
                end else begin
                    n_rb     = r_root;
                    sz_raddr = r_ra;
                end
            end
            ST_SIZE_A: begin
                n_sza    = sz_rdata;
                sz_raddr = r_rb;
            end
            ST_SIZE_B: begin
                // ties keep node_a's root on top
                par_we    = 1'b1;
                par_waddr = a_small ? r_ra : r_rb;
                par_wdata = a_small ? r_rb : r_ra;
                sz_we     = 1'b1;
                sz_waddr  = a_small ? r_rb : r_ra;
                sz_wdata  = r_sza + sz_rdata;
                n_root    = a_small ? r_rb : r_ra;
                n_merged  = 1'b1;
                if (r_comp != '0) n_comp = r_comp - CNT_W'(1);
            end
            ST_RESULT: begin
                if (slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out.merged          = r_merged;
                    n_out.root_of_a       = r_err ? '0 : r_root;
                    n_out.a_is_root       = !r_err && (r_root == r_a);
                    n_out.component_count = r_comp;
                    n_out.range_error     = r_err;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
        if (i_init) begin
            n_clr  = '0;
            n_comp = i_init_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_comp      <= eff_count(NODE_COUNT_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_comp      <= n_comp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_err    <= n_err;
        r_phase  <= n_phase;
        r_cur    <= n_cur;
        r_idx    <= n_idx;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_sza    <= n_sza;
        r_merged <= n_merged;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_job_pop)
        else $error("job taken while back end busy");

    a_comp_writes_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && par_we) |-> (par_wdata == r_root && par_waddr != r_root))
        else $error("path compression writes wrong parent");

    a_merge_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIZE_B && r_comp != '0 && !i_init) |=>
            (r_comp == $past(r_comp) - CNT_W'(1)))
        else $error("component count not decremented on merge");
`endif

endmodule

### tb/sv/ufc_checker.sv
module ufc_checker
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in         i_item,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out        i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_W-1:0] parent [NODES];
    logic [CNT_W-1:0]  set_sz [NODES];
    logic [CNT_W-1:0]  comp_cnt;
    logic [CNT_W-1:0]  cnt_reg;
    t_out              expected_q[$];

    function automatic logic [CNT_W-1:0] active_nodes();
        logic [CNT_W-1:0] r;
        r = cnt_reg;
        if (r == '0) r = CNT_W'(1);
        else if (r > CNT_W'(NODES)) r = CNT_W'(NODES);
        return r;
    endfunction

    task automatic clear_sets();
        for (int i = 0; i < NODES; i++) begin
            parent[i] = ADDR_W'(i);
            set_sz[i] = CNT_W'(1);
        end
        comp_cnt = active_nodes();
    endtask

    function automatic logic [ADDR_W-1:0] root_compress(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] r;
        logic [ADDR_W-1:0] nxt;
        r = idx;
        while (parent[r] != r) r = parent[r];
        while (idx != r) begin
            nxt = parent[idx];
            parent[idx] = r;
            idx = nxt;
        end
        return r;
    endfunction

    function automatic t_out apply_cmd(input t_in it);
        t_out o;
        logic [ADDR_W-1:0] ra, rb, big, lil;
        logic [CNT_W-1:0] n;
        o = '0;
        n = active_nodes();
        if ({1'b0, it.node_a} >= n || (it.command == CMD_UNION && {1'b0, it.node_b} >= n)) begin
            o.range_error = 1'b1;
        end else if (it.command == CMD_FIND) begin
            o.root_of_a = root_compress(it.node_a);
            o.a_is_root = (o.root_of_a == it.node_a);
        end else begin
            ra = root_compress(it.node_a);
            rb = root_compress(it.node_b);
            if (ra != rb) begin
                big = ra;
                lil = rb;
                if (set_sz[ra] < set_sz[rb]) begin
                    big = rb;
                    lil = ra;
                end
                parent[lil] = big;
                set_sz[big] = set_sz[big] + set_sz[lil];
                if (comp_cnt != '0) comp_cnt = comp_cnt - CNT_W'(1);
                o.merged = 1'b1;
                ra = big;
            end
            o.root_of_a = ra;
            o.a_is_root = (ra == it.node_a);
        end
        o.component_count = comp_cnt;
        return o;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            cnt_reg = NODE_COUNT_RST;
            clear_sets();
            expected_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_NODE_COUNT) begin
                cnt_reg = i_pwdata[CNT_W-1:0];
                clear_sets();
            end
            if (i_push && !i_full) expected_q.insert(expected_q.size(), apply_cmd(i_item));
            if (i_pop && !i_empty) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_result !== exp_res) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", exp_res, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb.sv
module tb;
    import ufc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in         item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          cycles = 0;
    int          items_sent = 0;
    logic [CNT_W-1:0] cur_nodes = NODE_COUNT_RST;

    always #10 clk = ~clk;

    union_find_components u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .o_full(full), .i_item(item),
        .o_empty(empty), .i_pop(pop), .o_result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ufc_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .i_full(full), .i_item(item),
        .i_empty(empty), .i_pop(pop), .i_result(result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // result side stalls at random
    always @(posedge clk) begin
        if (!rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 900000) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // push stays high after the accepting edge; the next call or drain decides
    task automatic send_item(input t_cmd c, input int a, input int b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{command: c, node_a: ADDR_W'(a), node_b: ADDR_W'(b)};
        // full is stable at the falling edge and holds through the next rising edge
        @(negedge clk);
        while (full) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_nodes(input int v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_nodes = eff_count(CNT_W'(v));
    endtask

    // mostly in-range indices, some drawn from all of 0..1023, which can lie past the active count
    function automatic int pick_node();
        int n;
        n = int'(cur_nodes);
        if ($urandom_range(19) == 0) return $urandom_range(1023);
        return $urandom_range(n - 1);
    endfunction

    task automatic random_run(input int count);
        repeat (count) begin
            if ($urandom_range(2) == 0) send_item(CMD_FIND, pick_node(), $urandom_range(1023));
            else send_item(CMD_UNION, pick_node(), pick_node());
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, self union, same-set union, ties, range errors
        send_item(CMD_FIND, 0, 1023);
        send_item(CMD_FIND, 1023, 0);
        send_item(CMD_UNION, 0, 0);
        send_item(CMD_UNION, 0, 1023);
        send_item(CMD_UNION, 1023, 0);
        send_item(CMD_UNION, 1, 2);
        send_item(CMD_UNION, 3, 1);
        send_item(CMD_FIND, 2, 0);
        send_item(CMD_FIND, 1023, 0);
        send_item(CMD_UNION, 682, 341);
        write_nodes(5);
        send_item(CMD_UNION, 5, 0);
        send_item(CMD_UNION, 0, 5);
        send_item(CMD_FIND, 5, 0);
        send_item(CMD_FIND, 4, 1023);
        for (int i = 1; i < 5; i++) send_item(CMD_UNION, 0, i);
        send_item(CMD_FIND, 4, 0);
        write_nodes(0);
        send_item(CMD_FIND, 0, 1023);
        send_item(CMD_UNION, 0, 1);
        write_nodes(2047);
        send_item(CMD_UNION, 1023, 1022);
        send_item(CMD_FIND, 1022, 0);

        write_nodes(16);
        random_run(250);
        send_idle_pct = 57;
        write_nodes(1);
        random_run(60);
        write_nodes(64);
        random_run(200);
        drain(); // sender holds off until every result is back
        send_idle_pct = 0;
        pop_stall_pct = 57;
        write_nodes(1024);
        random_run(200);
        write_nodes(300);
        send_idle_pct = 23;
        pop_stall_pct = 23;
        random_run(250);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        write_nodes(1025);
        random_run(120);

        drain();
        $display("sent %0d items, checked %0d results across node counts 0..2047",
                 items_sent, results_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### sim.f
hdl/ufc_pkg.sv
hdl/ufc_ram.sv
hdl/ufc_front.sv
hdl/ufc_back.sv
hdl/union_find_components.sv
tb/sv/ufc_checker.sv
tb/sv/tb.sv
